@@ rtl/core/atm3_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atm3_pkg
// Shared types, register indexes and helpers of the 3x3 alpha-trimmed mean.
// ----------------------------------------------------------------------------
package atm3_pkg;

  localparam int unsigned NumTaps       = 9;
  localparam int unsigned NumLanes      = 4;
  localparam int unsigned RecipW        = 17;
  localparam int unsigned RecipSh       = 16;
  // line length and channel limits; coordinate port widths follow from these
  localparam int unsigned MaxLinePixels = 2048;
  localparam int unsigned MaxChannels   = 4;

  typedef logic [7:0] pix_t;
  typedef pix_t [NumTaps-1:0] win_t;

  localparam logic [2:0] RegImageWidth   = 3'd0;
  localparam logic [2:0] RegImageHeight  = 3'd1;
  localparam logic [2:0] RegChannelCount = 3'd2;
  localparam logic [2:0] RegTrimEachSide = 3'd3;

  // one odd-even transposition round; odd selects pairs (1,2),(3,4)...
  function automatic win_t sort_round(win_t v, logic odd);
    win_t r;
    r = v;
    for (int i = 0; i + 1 < NumTaps; i++) begin
      if ((i[0] == odd) && (v[i] > v[i+1])) begin
        r[i]   = v[i+1];
        r[i+1] = v[i];
      end
    end
    return r;
  endfunction

  // 2^16 / (9 - 2*trim), rounded up; exact for sums up to 9*255
  function automatic logic [RecipW-1:0] recip(logic [2:0] trim);
    logic [RecipW-1:0] m;
    case (trim)
      3'd0:    m = 17'd7282;
      3'd1:    m = 17'd9363;
      3'd2:    m = 17'd13108;
      3'd3:    m = 17'd21846;
      default: m = 17'd65536;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/core/alpha_trimmed_mean_3x3_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_trimmed_mean_3x3_top
// 3x3 alpha-trimmed mean over a raster sample stream, channels interleaved.
// ----------------------------------------------------------------------------
// Input beats carry one sample and a frame-start flag; output beats carry the
// filtered value, the centre column and row and the channel. A beat moves
// when valid is high and stall is low. Pixels within two of the frame edge
// give no output beat.
// One sample is taken every cycle unless in_stall_o is high; throughput is one
// beat per clock while the receiver does not stall. An input beat that
// completes a window reaches its output beat through eight register stages:
// line store read, window form, three stages of three sort rounds, sum of
// the kept values, reciprocal multiply and the output register.
// The whole pipeline advances together; when the receiver stalls while an
// output beat is held, the input is stalled in the same cycle and nothing is
// lost or repeated. Line stores are simple dual-port RAMs, one read and one
// write each beat, with a bypass for a write still in flight.
// Reset clears position counters, window registers and valid bits, and sets
// the registers to 640 x 480, one channel, trim of two. Line stores hold
// no reset value and are valid once a frame has filled them.
// Configuration writes are taken at any edge with cfg_we_i high.
// ----------------------------------------------------------------------------
module alpha_trimmed_mean_3x3_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  sample_i,
  input  logic        frame_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  filtered_value_o,
  output logic [10:0] centre_column_o,
  output logic [11:0] centre_row_o,
  output logic [1:0]  channel_index_o
);
  import atm3_pkg::*;

  localparam int unsigned Depth = MaxLinePixels * MaxChannels;
  localparam int unsigned AddrW = $clog2(Depth);

  // configuration
  logic [11:0] width_q;
  logic [12:0] height_q;
  logic [2:0]  chan_q, trim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 12'd640;
      height_q <= 13'd480;
      chan_q   <= 3'd1;
      trim_q   <= 3'd2;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegImageWidth:   width_q  <= cfg_data_i[11:0];
        RegImageHeight:  height_q <= cfg_data_i;
        RegChannelCount: chan_q   <= cfg_data_i[2:0];
        RegTrimEachSide: trim_q   <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  logic [12:0] w_c, h_c;
  logic [2:0]  ch_c, trim_c;

  always_comb begin
    w_c = {1'b0, width_q};
    if (width_q < 12'd5) w_c = 13'd5;
    else if ({1'b0, width_q} > 13'(MaxLinePixels)) w_c = 13'(MaxLinePixels);
    h_c = height_q;
    if (height_q < 13'd5) h_c = 13'd5;
    else if (height_q > 13'd4096) h_c = 13'd4096;
    ch_c = chan_q;
    if (chan_q == 3'd0) ch_c = 3'd1;
    else if (chan_q > 3'(MaxChannels)) ch_c = 3'(MaxChannels);
    trim_c = (trim_q > 3'd4) ? 3'd4 : trim_q;
  end

  // pipeline enable
  logic en, acc;
  assign in_stall_o = out_valid_o && out_stall_i;
  assign en  = !in_stall_o;
  assign acc = in_valid_i && en;

  // position counters
  logic [10:0] col_q, col_d, c_now;
  logic [11:0] row_q, row_d, r_now;
  logic [1:0]  chn_q, chn_d, n_now;
  logic        emit_now;
  logic [12:0] addr_raw;
  logic [AddrW-1:0] addr_now;

  always_comb begin
    c_now = frame_start_i ? 11'd0 : col_q;
    r_now = frame_start_i ? 12'd0 : row_q;
    n_now = frame_start_i ? 2'd0  : chn_q;
    col_d = c_now;
    row_d = r_now;
    chn_d = n_now + 2'd1;
    if ({1'b0, n_now} + 3'd1 >= ch_c) begin
      chn_d = 2'd0;
      if ({2'b0, c_now} + 13'd1 >= w_c) begin
        col_d = 11'd0;
        row_d = ({1'b0, r_now} + 13'd1 >= h_c) ? 12'd0 : r_now + 12'd1;
      end else begin
        col_d = c_now + 11'd1;
      end
    end
    emit_now = (c_now >= 11'd3) && ({2'b0, c_now} + 13'd2 <= w_c) &&
               (r_now >= 12'd3) && ({1'b0, r_now} + 13'd2 <= h_c);
    // column below 2048 and at most four channels: always inside the store
    addr_raw = 13'({2'b0, c_now} * {10'b0, ch_c}) + {11'b0, n_now};
    addr_now = addr_raw[AddrW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      chn_q <= '0;
    end else if (acc) begin
      col_q <= col_d;
      row_q <= row_d;
      chn_q <= chn_d;
    end
  end

  // stage 1: line store read
  pix_t upper_mem [Depth];
  pix_t middle_mem [Depth];
  pix_t rd_up_q, rd_mid_q, fwd_up_q, fwd_mid_q;
  logic fwd_q;
  logic v1_q, e1_q;
  pix_t s1_q;
  logic [AddrW-1:0] a1_q;
  logic [10:0] c1_q;
  logic [11:0] r1_q;
  logic [1:0]  n1_q;
  pix_t up1, mid1;

  assign up1  = fwd_q ? fwd_up_q  : rd_up_q;
  assign mid1 = fwd_q ? fwd_mid_q : rd_mid_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rd_up_q   <= upper_mem[addr_now];
      rd_mid_q  <= middle_mem[addr_now];
      if (v1_q) begin
        upper_mem[a1_q]  <= mid1;
        middle_mem[a1_q] <= s1_q;
      end
      // bypass the write that lands in the same cycle as this read
      fwd_q     <= v1_q && (a1_q == addr_now);
      fwd_up_q  <= mid1;
      fwd_mid_q <= s1_q;
      s1_q <= sample_i;
      a1_q <= addr_now;
      c1_q <= c_now;
      r1_q <= r_now;
      n1_q <= n_now;
      e1_q <= emit_now;
    end
  end

  // stage 2: window form
  win_t lane_q [NumLanes];
  win_t win_new;
  win_t w2_q, w3_q, w4_q, w5_q;
  logic [10:0] c2_q, c3_q, c4_q, c5_q, c6_q, c7_q;
  logic [11:0] r2_q, r3_q, r4_q, r5_q, r6_q, r7_q;
  logic [1:0]  n2_q, n3_q, n4_q, n5_q, n6_q, n7_q;
  logic v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;

  always_comb begin
    win_new = lane_q[n1_q];
    for (int k = 0; k < 6; k++) win_new[k] = lane_q[n1_q][k+3];
    win_new[6] = up1;
    win_new[7] = mid1;
    win_new[8] = s1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < NumLanes; l++) lane_q[l] <= '0;
    end else if (en && v1_q) begin
      lane_q[n1_q] <= win_new;
    end
  end

  // stages 3..5: nine transposition rounds, three per stage
  logic [11:0] sum6_d, sum6_q;
  logic [RecipW+11:0] prod7_q;

  always_comb begin
    sum6_d = '0;
    for (int i = 0; i < NumTaps; i++) begin
      if ((4'(i) >= {1'b0, trim_c}) && (4'(i) <= 4'd8 - {1'b0, trim_c}))
        sum6_d = sum6_d + {4'b0, w5_q[i]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w2_q <= win_new;
      c2_q <= c1_q - 11'd1;
      r2_q <= r1_q - 12'd1;
      n2_q <= n1_q;
      w3_q <= sort_round(sort_round(sort_round(w2_q, 1'b0), 1'b1), 1'b0);
      w4_q <= sort_round(sort_round(sort_round(w3_q, 1'b1), 1'b0), 1'b1);
      w5_q <= sort_round(sort_round(sort_round(w4_q, 1'b0), 1'b1), 1'b0);
      c3_q <= c2_q; r3_q <= r2_q; n3_q <= n2_q;
      c4_q <= c3_q; r4_q <= r3_q; n4_q <= n3_q;
      c5_q <= c4_q; r5_q <= r4_q; n5_q <= n4_q;
      sum6_q <= sum6_d;
      c6_q <= c5_q; r6_q <= r5_q; n6_q <= n5_q;
      prod7_q <= {{RecipW{1'b0}}, sum6_q} * {12'b0, recip(trim_c)};
      c7_q <= c6_q; r7_q <= r6_q; n7_q <= n6_q;
      filtered_value_o <= prod7_q[RecipSh +: 8];
      centre_column_o  <= c7_q;
      centre_row_o     <= r7_q;
      channel_index_o  <= n7_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0; out_valid_o <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q && e1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      out_valid_o <= v7_q;
    end
  end

endmodule
